// ===== rtl/clamped_pi_controller_with_override_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clamped PI controller
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_PI_CONTROLLER_WITH_OVERRIDE_CORE_MACROS_SVH
`define CLAMPED_PI_CONTROLLER_WITH_OVERRIDE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CPIC_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error("cpic: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CPIC_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("cpic: next-cycle check failed");
`else
`define CPIC_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons)
`define CPIC_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)
`endif

`endif

// ===== rtl/cpic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpic_pkg
// Types and constants shared by the clamped PI controller modules.
// ----------------------------------------------------------------------------
package cpic_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_TARGET      = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_BIAS        = 3'd3,
    REG_ERROR_LIMIT = 3'd4,
    REG_SUM_LIMIT   = 3'd5,
    REG_OUT_MAX     = 3'd6
  } cpic_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  typedef struct packed {
    logic [9:0]        target;
    logic signed [7:0] gain_p;
    logic signed [7:0] gain_i;
    logic [8:0]        bias;
    logic [7:0]        error_limit;
    logic [10:0]       sum_limit;
    logic [8:0]        out_max;
  } cpic_cfg_t;

  localparam cpic_cfg_t CfgReset = '{
    target:      10'd143,
    gain_p:      -8'sd72,
    gain_i:      -8'sd4,
    bias:        9'd128,
    error_limit: 8'd56,
    sum_limit:   11'd1024,
    out_max:     9'd255
  };

  // One input transaction as held in the input register.
  typedef struct packed {
    logic signed [10:0] measured;
    logic               hold_active;
    logic [7:0]         hold_value;
    logic               clear_sum;
  } cpic_in_t;

  // Error and integral handed to the drive stage.
  typedef struct packed {
    logic signed [8:0]  error_used;
    logic signed [11:0] integral;
    logic               hold_active;
    logic [7:0]         hold_value;
  } cpic_mid_t;

endpackage

// ===== rtl/cpic_err.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpic_err
// Forms the clamped error and the clamped integral update.
// ----------------------------------------------------------------------------
module cpic_err import cpic_pkg::*; (
  input  cpic_cfg_t          cfg,
  input  cpic_in_t           item,
  input  logic signed [11:0] sum_q,
  output cpic_mid_t          mid
);

  logic signed [11:0] diff;
  logic signed [11:0] elim;
  logic signed [8:0]  err;
  logic signed [11:0] sum_base;
  logic signed [12:0] sum_raw;
  logic signed [12:0] slim;
  logic signed [11:0] sum_new;

  assign diff = $signed({2'b00, cfg.target}) - $signed({item.measured[10], item.measured});
  assign elim = $signed({4'b0000, cfg.error_limit});

  always_comb begin
    if (diff > elim) begin
      err = elim[8:0];
    end else if (diff < -elim) begin
      err = 9'(-elim);
    end else begin
      err = diff[8:0];
    end
  end

  // A clear request zeroes the integral before this step's error goes in.
  assign sum_base = item.clear_sum ? 12'sd0 : sum_q;
  assign sum_raw  = $signed({sum_base[11], sum_base}) + $signed({{4{err[8]}}, err});
  assign slim     = $signed({2'b00, cfg.sum_limit});

  always_comb begin
    if (sum_raw > slim) begin
      sum_new = slim[11:0];
    end else if (sum_raw < -slim) begin
      sum_new = 12'(-slim);
    end else begin
      sum_new = sum_raw[11:0];
    end
  end

  assign mid.error_used  = err;
  assign mid.integral    = sum_new;
  assign mid.hold_active = item.hold_active;
  assign mid.hold_value  = item.hold_value;

endmodule

// ===== rtl/cpic_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpic_drive
// Scales P and I terms, adds bias, applies hold and the output clamp.
// ----------------------------------------------------------------------------
module cpic_drive import cpic_pkg::*; #(
  parameter int GAIN_SHIFT = 4
) (
  input  cpic_cfg_t  cfg,
  input  cpic_mid_t  mid,
  output logic [8:0] drive
);

  localparam int PW = 17;
  localparam int IW = 20;
  localparam int SW = 21;
  localparam logic signed [PW-1:0] RndP = PW'((1 << GAIN_SHIFT) - 1);
  localparam logic signed [IW-1:0] RndI = IW'((1 << GAIN_SHIFT) - 1);

  logic signed [PW-1:0] p_prod;
  logic signed [IW-1:0] i_prod;
  logic signed [PW-1:0] p_term;
  logic signed [IW-1:0] i_term;
  logic signed [SW-1:0] total;
  logic signed [SW-1:0] pre;
  logic signed [SW-1:0] omax;

  assign p_prod = $signed({{9{cfg.gain_p[7]}}, cfg.gain_p})
                * $signed({{8{mid.error_used[8]}}, mid.error_used});
  assign i_prod = $signed({{12{cfg.gain_i[7]}}, cfg.gain_i})
                * $signed({{8{mid.integral[11]}}, mid.integral});

  // Adding divisor minus one to negative products makes the shift round
  // toward zero, matching signed integer division. Both arms of the select
  // are signed so the shift stays arithmetic.
  assign p_term = (p_prod + (p_prod[PW-1] ? RndP : PW'(0))) >>> GAIN_SHIFT;
  assign i_term = (i_prod + (i_prod[IW-1] ? RndI : IW'(0))) >>> GAIN_SHIFT;

  assign total = $signed({12'd0, cfg.bias})
               + $signed({{(SW-PW){p_term[PW-1]}}, p_term})
               + $signed({{(SW-IW){i_term[IW-1]}}, i_term});

  assign pre  = mid.hold_active ? $signed({13'd0, mid.hold_value}) : total;
  assign omax = $signed({12'd0, cfg.out_max});

  always_comb begin
    if (pre < 0) begin
      drive = 9'd0;
    end else if (pre > omax) begin
      drive = cfg.out_max;
    end else begin
      drive = pre[8:0];
    end
  end

endmodule

// ===== rtl/clamped_pi_controller_with_override_core.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while out_ready does not stall the result channel.
// Stages: input register, error/integral register, output register.
// Reset (rst_n low, synchronous): all valid flags drop, the integral returns to
// zero and every configuration register returns to its documented default.
// ----------------------------------------------------------------------------
// clamped_pi_controller_with_override_core
// PI controller with error and integral clamps, hold override and output clamp.
// ----------------------------------------------------------------------------
`include "clamped_pi_controller_with_override_core_macros.svh"

module clamped_pi_controller_with_override_core import cpic_pkg::*; #(
  parameter int GAIN_SHIFT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_idx,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [10:0]   in_measured,
  input  logic                 in_hold_active,
  input  logic [7:0]           in_hold_value,
  input  logic                 in_clear_sum,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [8:0]           out_drive,
  output logic signed [8:0]    out_error_used,
  output logic signed [11:0]   out_integral
);

  // Configuration registers. The user must write them only while the block is idle;
  // the block itself does not enforce this, and every stage reads them directly.
  cpic_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET:      cfg_r.target      <= cfg_wdata[9:0];
        REG_GAIN_P:      cfg_r.gain_p      <= $signed(cfg_wdata[7:0]);
        REG_GAIN_I:      cfg_r.gain_i      <= $signed(cfg_wdata[7:0]);
        REG_BIAS:        cfg_r.bias        <= cfg_wdata[8:0];
        REG_ERROR_LIMIT: cfg_r.error_limit <= cfg_wdata[7:0];
        REG_SUM_LIMIT:   cfg_r.sum_limit   <= cfg_wdata[10:0];
        REG_OUT_MAX:     cfg_r.out_max     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Each stage accepts when it is empty or moving on in the
  // same cycle, so a waiting result never stops new transactions upstream
  // until every stage is full.
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s2_ready;
  logic s1_adv;
  logic in_acc;

  assign out_adv  = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_ready = !s2_valid_r || out_adv;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register.
  cpic_in_t s1_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.measured    <= in_measured;
      s1_r.hold_active <= in_hold_active;
      s1_r.hold_value  <= in_hold_value;
      s1_r.clear_sum   <= in_clear_sum;
    end
  end

  // Error and integral stage. The stored integral advances exactly when a
  // transaction leaves the input register, so consecutive transactions see
  // each other's updates with no gap.
  logic signed [11:0] error_sum_r;
  cpic_mid_t          mid_nxt;
  cpic_mid_t          s2_r;

  cpic_err u_err (
    .cfg   (cfg_r),
    .item  (s1_r),
    .sum_q (error_sum_r),
    .mid   (mid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= 12'sd0;
    end else if (s1_adv) begin
      error_sum_r <= mid_nxt.integral;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r <= mid_nxt;
    end
  end

  // Drive stage: two parallel multiplies, bias sum, hold select and clamp.
  logic [8:0]         drive_nxt;
  logic [8:0]         out_drive_r;
  logic signed [8:0]  out_error_used_r;
  logic signed [11:0] out_integral_r;

  cpic_drive #(
    .GAIN_SHIFT (GAIN_SHIFT)
  ) u_drive (
    .cfg   (cfg_r),
    .mid   (s2_r),
    .drive (drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_drive_r      <= drive_nxt;
      out_error_used_r <= s2_r.error_used;
      out_integral_r   <= s2_r.integral;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_error_used = out_error_used_r;
  assign out_integral   = out_integral_r;

  // A presented result never exceeds the configured drive ceiling.
  `CPIC_ASSERT_NOW(a_drive_max, clk, rst_n, out_valid_r, out_drive_r <= cfg_r.out_max)
  // The reported error lies inside the symmetric error clamp.
  `CPIC_ASSERT_NOW(a_err_lim, clk, rst_n, out_valid_r, (out_error_used_r <= $signed({1'b0, cfg_r.error_limit})) && (out_error_used_r >= -$signed({1'b0, cfg_r.error_limit})))
  // The reported integral lies inside the symmetric integral clamp.
  `CPIC_ASSERT_NOW(a_int_lim, clk, rst_n, out_valid_r, (out_integral_r <= $signed({1'b0, cfg_r.sum_limit})) && (out_integral_r >= -$signed({1'b0, cfg_r.sum_limit})))
  // A transaction leaving the input register always lands in the middle stage.
  `CPIC_ASSERT_NEXT(a_s2_fill, clk, rst_n, s1_adv, s2_valid_r && (error_sum_r == s2_r.integral))

endmodule
